FILE: rtl/core/dram_pim_bank_state_tracker_assert.svh
// Assertion macros for the DRAM bank state tracker.
// Expects clk and rst_n in the scope of use.
`ifndef DRAM_PIM_BANK_STATE_TRACKER_ASSERT_SVH
`define DRAM_PIM_BANK_STATE_TRACKER_ASSERT_SVH

// Same-cycle implication
`define DPBST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define DPBST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/dpbst_pkg.sv
// Types and constants for the DRAM bank state tracker.
// No dependencies.
package dpbst_pkg;

  typedef logic signed [16:0] row_t;
  typedef logic [63:0]        cyc_t;
  typedef logic [3:0]         kind_t;

  localparam row_t ROW_NONE = -17'sd1;
  localparam logic [16:0] RPS_RESET = 17'd512;
  localparam int DIV_STEPS = 17;

  localparam logic [1:0] BANK_CLOSED = 2'd0;
  localparam logic [1:0] BANK_OPEN   = 2'd1;
  localparam logic [1:0] BANK_SREF   = 2'd2;

  localparam kind_t KIND_RD      = 4'd0;
  localparam kind_t KIND_RDP     = 4'd1;
  localparam kind_t KIND_WR      = 4'd2;
  localparam kind_t KIND_WRP     = 4'd3;
  localparam kind_t KIND_ACT     = 4'd4;
  localparam kind_t KIND_PRE     = 4'd5;
  localparam kind_t KIND_REF     = 4'd6;
  localparam kind_t KIND_SREFIN  = 4'd7;
  localparam kind_t KIND_SREFOUT = 4'd8;
  localparam kind_t KIND_D2G     = 4'd9;
  localparam kind_t KIND_H2G     = 4'd10;
  localparam kind_t KIND_COMP    = 4'd11;
  localparam kind_t KIND_MAC     = 4'd12;
  localparam kind_t KIND_MACINTR = 4'd13;
  localparam kind_t KIND_READRES = 4'd14;
  localparam kind_t KIND_PWRITE  = 4'd15;

  localparam logic [3:0] REQ_QUERY      = 4'd0;
  localparam logic [3:0] REQ_APPLY      = 4'd1;
  localparam logic [3:0] REQ_T_SAME     = 4'd2;
  localparam logic [3:0] REQ_T_DIFF     = 4'd3;
  localparam logic [3:0] REQ_T_MAC_SAME = 4'd4;
  localparam logic [3:0] REQ_T_MAC_DIFF = 4'd5;
  localparam logic [3:0] REQ_ACT_DONE   = 4'd6;
  localparam logic [3:0] REQ_CLR_MAC    = 4'd7;
  localparam logic [3:0] REQ_CLR_MACD   = 4'd8;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_ILLEGAL = 2'd1;
  localparam logic [1:0] ERR_STATE   = 2'd2;

  localparam logic [2:0] CFG_ADDR_MODE = 3'd0;
  localparam logic [2:0] CFG_ADDR_RPS  = 3'd4;

  typedef enum logic [4:0] {
    SEQ_IDLE = 5'b00001,
    SEQ_DIV  = 5'b00010,
    SEQ_EVAL = 5'b00100,
    SEQ_UPD  = 5'b01000,
    SEQ_FIN  = 5'b10000
  } seq_t;

endpackage

FILE: rtl/core/dpbst_in_if.sv
// Request channel of the DRAM bank state tracker.
// Depends on dpbst_pkg.
interface dpbst_in_if;
  logic              valid;
  logic              ready;
  logic [3:0]        req_type;
  dpbst_pkg::kind_t  cmd_kind;
  dpbst_pkg::row_t   row;
  logic              for_pim;
  dpbst_pkg::cyc_t   now;
  dpbst_pkg::cyc_t   time_value;

  modport source(output valid, req_type, cmd_kind, row, for_pim, now, time_value,
                 input ready);
  modport sink(input valid, req_type, cmd_kind, row, for_pim, now, time_value,
               output ready);
endinterface

FILE: rtl/core/dpbst_out_if.sv
// Result channel of the DRAM bank state tracker.
// Depends on dpbst_pkg.
interface dpbst_out_if;
  logic             valid;
  logic             ready;
  logic             ready_res;
  dpbst_pkg::kind_t ready_kind;
  logic             ready_for_pim;
  logic [31:0]      row_hits;
  logic [1:0]       error_code;

  modport source(output valid, ready_res, ready_kind, ready_for_pim, row_hits, error_code,
                 input ready);
  modport sink(input valid, ready_res, ready_kind, ready_for_pim, row_hits, error_code,
               output ready);
endinterface

FILE: rtl/core/dram_pim_bank_state_tracker.sv
// DRAM bank state tracker with a normal and a compute-path open row.
// Depends on dpbst_pkg, dpbst_in_if, dpbst_out_if and the assertion header.
//
// One request at a time. Query and apply requests run three subarray numbers
// (request row, normal open row, compute open row) one after another through
// one shared restoring divider, then pass the evaluate state and the result
// state. Timing-table requests skip the divider and go through the update
// state to the result state. The block takes a new request once the result is
// registered; a result still waiting on the output only holds the next one at
// its last step.
module dram_pim_bank_state_tracker (
  input  logic               clk,
  input  logic               rst_n,
  dpbst_in_if.sink           in_ch,
  dpbst_out_if.source        out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  dpbst_pkg::seq_t state_r;

  logic        mode_r;
  logic [16:0] rps_r;

  logic [3:0]        req_r;
  dpbst_pkg::kind_t  kind_r;
  dpbst_pkg::row_t   row_l_r;
  logic              pim_r;
  dpbst_pkg::cyc_t   now_r;
  dpbst_pkg::cyc_t   tv_r;

  logic [1:0]       ns_r, ps_r;
  dpbst_pkg::row_t  nrow_r, prow_r, prech_r;
  logic [31:0]      hits_r;
  dpbst_pkg::cyc_t  same_r [16];
  dpbst_pkg::cyc_t  diff_r [16];
  dpbst_pkg::cyc_t  macs_r [16];
  dpbst_pkg::cyc_t  macd_r [16];
  dpbst_pkg::cyc_t  act_done_r;
  logic [3:0]       tidx_r;

  logic [16:0]      dvd_r, rem_r, quo_r;
  logic [4:0]       cnt_r;
  logic [1:0]       idx_r;
  dpbst_pkg::row_t  sa_row_r, sa_n_r, sa_p_r;

  dpbst_pkg::kind_t rk_r;
  logic [1:0]       err_r;
  logic             imm_r, use_diff_r, use_macd_r, use_act_r;

  logic             out_valid_r, out_res_r, out_pim_r;
  dpbst_pkg::kind_t out_kind_r;
  logic [31:0]      out_hits_r;
  logic [1:0]       out_err_r;

  // config port
  logic cfg_wr;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_comb begin
    case (cfg_paddr)
      dpbst_pkg::CFG_ADDR_MODE: cfg_prdata = {31'd0, mode_r};
      dpbst_pkg::CFG_ADDR_RPS:  cfg_prdata = {15'd0, rps_r};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  // shared divider
  dpbst_pkg::row_t div_src, sa_val;
  logic [16:0] divisor, src_mag, rem_next, q_fin;
  logic [17:0] trial, trial_sub;
  logic        q_bit;
  always_comb begin
    case (idx_r)
      2'd0:    div_src = row_l_r;
      2'd1:    div_src = nrow_r;
      default: div_src = prow_r;
    endcase
    divisor   = (rps_r == 17'd0) ? 17'd1 : rps_r;
    src_mag   = div_src[16] ? 17'(-div_src) : 17'(div_src);
    trial     = {rem_r, dvd_r[16]};
    trial_sub = trial - {1'b0, divisor};
    q_bit     = (trial >= {1'b0, divisor});
    rem_next  = q_bit ? trial_sub[16:0] : trial[16:0];
    q_fin     = {quo_r[15:0], q_bit};
    if (div_src == dpbst_pkg::ROW_NONE) begin
      sa_val = dpbst_pkg::ROW_NONE;
    end else if (div_src[16]) begin
      sa_val = dpbst_pkg::row_t'(-q_fin);
    end else begin
      sa_val = dpbst_pkg::row_t'(q_fin);
    end
  end

  // query decision
  logic [1:0]       q_st, q_err;
  dpbst_pkg::kind_t q_req;
  logic             q_imm, row_match, same_sub, q_diff, q_macd, q_act;
  logic [17:0]      sa_d;
  dpbst_pkg::row_t  sa_other, own_sa;
  always_comb begin
    q_err = dpbst_pkg::ERR_NONE;
    q_imm = 1'b0;
    q_req = kind_r;
    if (pim_r) begin
      q_st = (ns_r == dpbst_pkg::BANK_OPEN && sa_row_r == sa_n_r) ? dpbst_pkg::BANK_OPEN : ps_r;
    end else begin
      q_st = (ps_r == dpbst_pkg::BANK_OPEN && sa_row_r == sa_p_r) ? dpbst_pkg::BANK_OPEN : ns_r;
    end
    if (q_st == dpbst_pkg::BANK_CLOSED) begin
      case (kind_r)
        dpbst_pkg::KIND_RD, dpbst_pkg::KIND_WR, dpbst_pkg::KIND_D2G,
        dpbst_pkg::KIND_COMP, dpbst_pkg::KIND_MAC: q_req = dpbst_pkg::KIND_ACT;
        dpbst_pkg::KIND_REF: begin
          q_req = dpbst_pkg::KIND_REF;
          q_imm = (ps_r != dpbst_pkg::BANK_CLOSED);
        end
        dpbst_pkg::KIND_H2G, dpbst_pkg::KIND_READRES,
        dpbst_pkg::KIND_MACINTR: q_req = kind_r;
        default: q_err = dpbst_pkg::ERR_ILLEGAL;
      endcase
    end else if (q_st == dpbst_pkg::BANK_OPEN) begin
      case (kind_r)
        dpbst_pkg::KIND_RD, dpbst_pkg::KIND_WR, dpbst_pkg::KIND_D2G:
          q_req = (row_l_r == nrow_r) ? kind_r : dpbst_pkg::KIND_PRE;
        dpbst_pkg::KIND_REF: q_req = dpbst_pkg::KIND_PRE;
        dpbst_pkg::KIND_COMP, dpbst_pkg::KIND_MAC:
          q_req = (row_l_r == (pim_r ? prow_r : nrow_r)) ? kind_r : dpbst_pkg::KIND_PRE;
        dpbst_pkg::KIND_READRES, dpbst_pkg::KIND_H2G,
        dpbst_pkg::KIND_MACINTR: q_req = kind_r;
        default: q_err = dpbst_pkg::ERR_ILLEGAL;
      endcase
    end else begin
      q_err = dpbst_pkg::ERR_STATE;
    end
    sa_other  = pim_r ? sa_n_r : sa_p_r;
    own_sa    = pim_r ? sa_p_r : sa_n_r;
    sa_d      = {sa_row_r[16], sa_row_r} - {sa_other[16], sa_other};
    same_sub  = (sa_d == 18'd0) || (sa_d == 18'd1) || (sa_d == 18'h3FFFF);
    row_match = pim_r ? (row_l_r == prow_r) : (sa_row_r == sa_n_r);
    if (q_req == dpbst_pkg::KIND_ACT && prech_r == sa_row_r) begin
      row_match = 1'b1;
    end
    q_diff = 1'b0;
    q_macd = 1'b0;
    q_act  = 1'b0;
    if (mode_r) begin
      if (same_sub && row_match) begin
        q_diff = 1'b0;
      end else if (!same_sub && !row_match) begin
        q_diff = 1'b1;
        q_macd = 1'b1;
      end else if (pim_r && !same_sub && row_match) begin
        q_diff = 1'b1;
        q_act  = 1'b1;
      end else if (!pim_r && same_sub && !row_match) begin
        q_diff = 1'b1;
      end else begin
        q_macd = 1'b1;
      end
    end
  end

  // apply decision
  logic [1:0]      a_ns_nxt, a_ps_nxt, a_err;
  dpbst_pkg::row_t a_nrow_nxt, a_prow_nxt;
  logic [31:0]     a_hits_nxt;
  logic [1:0]      a_st;
  always_comb begin
    a_ns_nxt   = ns_r;
    a_ps_nxt   = ps_r;
    a_nrow_nxt = nrow_r;
    a_prow_nxt = prow_r;
    a_hits_nxt = hits_r;
    a_err      = dpbst_pkg::ERR_NONE;
    a_st       = pim_r ? ps_r : ns_r;
    if (a_st == dpbst_pkg::BANK_OPEN) begin
      case (kind_r)
        dpbst_pkg::KIND_RD, dpbst_pkg::KIND_WR:
          if (hits_r != 32'hFFFF_FFFF) a_hits_nxt = hits_r + 32'd1;
        dpbst_pkg::KIND_READRES, dpbst_pkg::KIND_D2G, dpbst_pkg::KIND_H2G,
        dpbst_pkg::KIND_COMP, dpbst_pkg::KIND_MAC, dpbst_pkg::KIND_MACINTR: ;
        dpbst_pkg::KIND_PRE: begin
          if (pim_r) begin
            a_ps_nxt   = dpbst_pkg::BANK_CLOSED;
            a_prow_nxt = dpbst_pkg::ROW_NONE;
          end else begin
            a_ns_nxt   = dpbst_pkg::BANK_CLOSED;
            a_nrow_nxt = dpbst_pkg::ROW_NONE;
            a_hits_nxt = 32'd0;
          end
        end
        default: a_err = dpbst_pkg::ERR_ILLEGAL;
      endcase
    end else if (a_st == dpbst_pkg::BANK_CLOSED) begin
      case (kind_r)
        dpbst_pkg::KIND_REF, dpbst_pkg::KIND_H2G, dpbst_pkg::KIND_READRES: ;
        dpbst_pkg::KIND_ACT: begin
          if (pim_r) begin
            a_ps_nxt   = dpbst_pkg::BANK_OPEN;
            a_prow_nxt = row_l_r;
          end else begin
            a_ns_nxt   = dpbst_pkg::BANK_OPEN;
            a_nrow_nxt = row_l_r;
          end
        end
        dpbst_pkg::KIND_SREFIN: a_ns_nxt = dpbst_pkg::BANK_SREF;
        dpbst_pkg::KIND_PRE: begin
          if (mode_r) begin
            if (sa_row_r == sa_n_r) begin
              a_ns_nxt   = dpbst_pkg::BANK_CLOSED;
              a_nrow_nxt = dpbst_pkg::ROW_NONE;
              a_hits_nxt = 32'd0;
            end
            if (sa_row_r == sa_p_r) begin
              a_ps_nxt   = dpbst_pkg::BANK_CLOSED;
              a_prow_nxt = dpbst_pkg::ROW_NONE;
            end
          end else begin
            a_err = dpbst_pkg::ERR_ILLEGAL;
          end
        end
        default: a_err = dpbst_pkg::ERR_ILLEGAL;
      endcase
    end else begin
      a_err = dpbst_pkg::ERR_STATE;
    end
  end

  // readiness check against the selected tables
  dpbst_pkg::cyc_t tab_a, tab_b;
  logic            ready_q, fin_go, out_load;
  assign tab_a    = use_diff_r ? diff_r[tidx_r] : same_r[tidx_r];
  assign tab_b    = use_macd_r ? macd_r[tidx_r] : macs_r[tidx_r];
  assign ready_q  = (now_r >= tab_a) && (now_r >= tab_b) && (!use_act_r || now_r >= act_done_r);
  assign fin_go   = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == dpbst_pkg::SEQ_FIN) && fin_go;

  assign in_ch.ready          = (state_r == dpbst_pkg::SEQ_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.ready_res     = out_res_r;
  assign out_ch.ready_kind    = out_kind_r;
  assign out_ch.ready_for_pim = out_pim_r;
  assign out_ch.row_hits      = out_hits_r;
  assign out_ch.error_code    = out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dpbst_pkg::SEQ_IDLE;
      mode_r      <= 1'b0;
      rps_r       <= dpbst_pkg::RPS_RESET;
      ns_r        <= dpbst_pkg::BANK_CLOSED;
      ps_r        <= dpbst_pkg::BANK_CLOSED;
      nrow_r      <= dpbst_pkg::ROW_NONE;
      prow_r      <= dpbst_pkg::ROW_NONE;
      prech_r     <= dpbst_pkg::ROW_NONE;
      hits_r      <= 32'd0;
      act_done_r  <= 64'd0;
      out_valid_r <= 1'b0;
      cnt_r       <= 5'd0;
      idx_r       <= 2'd0;
      for (int i = 0; i < 16; i++) begin
        same_r[i] <= 64'd0;
        diff_r[i] <= 64'd0;
        macs_r[i] <= 64'd0;
        macd_r[i] <= 64'd0;
      end
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr == dpbst_pkg::CFG_ADDR_MODE) mode_r <= cfg_pwdata[0];
        if (cfg_paddr == dpbst_pkg::CFG_ADDR_RPS)  rps_r  <= cfg_pwdata[16:0];
      end
      if (out_valid_r && out_ch.ready && !out_load) out_valid_r <= 1'b0;

      case (state_r)
        dpbst_pkg::SEQ_IDLE: begin
          if (in_ch.valid) begin
            req_r   <= in_ch.req_type;
            kind_r  <= in_ch.cmd_kind;
            row_l_r <= in_ch.row;
            pim_r   <= in_ch.for_pim;
            now_r   <= in_ch.now;
            tv_r    <= in_ch.time_value;
            tidx_r  <= in_ch.cmd_kind;
            err_r   <= dpbst_pkg::ERR_NONE;
            imm_r   <= 1'b0;
            idx_r   <= 2'd0;
            cnt_r   <= 5'd0;
            if (in_ch.req_type == dpbst_pkg::REQ_QUERY ||
                in_ch.req_type == dpbst_pkg::REQ_APPLY) begin
              state_r <= dpbst_pkg::SEQ_DIV;
            end else begin
              state_r <= dpbst_pkg::SEQ_UPD;
            end
          end
        end
        dpbst_pkg::SEQ_DIV: begin
          if (cnt_r == 5'd0) begin
            dvd_r <= src_mag;
            rem_r <= 17'd0;
            quo_r <= 17'd0;
            cnt_r <= 5'd1;
          end else begin
            dvd_r <= {dvd_r[15:0], 1'b0};
            rem_r <= rem_next;
            quo_r <= q_fin;
            if (cnt_r == 5'(dpbst_pkg::DIV_STEPS)) begin
              cnt_r <= 5'd0;
              case (idx_r)
                2'd0:    sa_row_r <= sa_val;
                2'd1:    sa_n_r   <= sa_val;
                default: sa_p_r   <= sa_val;
              endcase
              if (idx_r == 2'd2) begin
                state_r <= dpbst_pkg::SEQ_EVAL;
              end else begin
                idx_r <= idx_r + 2'd1;
              end
            end else begin
              cnt_r <= cnt_r + 5'd1;
            end
          end
        end
        dpbst_pkg::SEQ_EVAL: begin
          if (req_r == dpbst_pkg::REQ_QUERY) begin
            rk_r       <= q_req;
            tidx_r     <= q_req;
            err_r      <= q_err;
            imm_r      <= q_imm && (q_err == dpbst_pkg::ERR_NONE);
            use_diff_r <= q_diff;
            use_macd_r <= q_macd;
            use_act_r  <= q_act;
            if (q_imm && q_err == dpbst_pkg::ERR_NONE) prech_r <= own_sa;
          end else begin
            err_r  <= a_err;
            ns_r   <= a_ns_nxt;
            ps_r   <= a_ps_nxt;
            nrow_r <= a_nrow_nxt;
            prow_r <= a_prow_nxt;
            hits_r <= a_hits_nxt;
          end
          state_r <= dpbst_pkg::SEQ_FIN;
        end
        dpbst_pkg::SEQ_UPD: begin
          case (req_r)
            dpbst_pkg::REQ_T_SAME:
              if (tv_r > same_r[tidx_r]) same_r[tidx_r] <= tv_r;
            dpbst_pkg::REQ_T_DIFF:
              if (tv_r > diff_r[tidx_r]) diff_r[tidx_r] <= tv_r;
            dpbst_pkg::REQ_T_MAC_SAME:
              if (tv_r > macs_r[tidx_r]) macs_r[tidx_r] <= tv_r;
            dpbst_pkg::REQ_T_MAC_DIFF:
              if (tv_r > macd_r[tidx_r]) macd_r[tidx_r] <= tv_r;
            dpbst_pkg::REQ_ACT_DONE:
              if (tv_r > act_done_r) act_done_r <= tv_r;
            dpbst_pkg::REQ_CLR_MAC:  macs_r[tidx_r] <= 64'd0;
            dpbst_pkg::REQ_CLR_MACD: macd_r[tidx_r] <= 64'd0;
            default: ;
          endcase
          state_r <= dpbst_pkg::SEQ_FIN;
        end
        dpbst_pkg::SEQ_FIN: begin
          if (fin_go) begin
            out_valid_r <= 1'b1;
            out_hits_r  <= hits_r;
            out_err_r   <= err_r;
            out_res_r   <= 1'b0;
            out_kind_r  <= dpbst_pkg::KIND_RD;
            out_pim_r   <= 1'b0;
            if (req_r == dpbst_pkg::REQ_QUERY && err_r == dpbst_pkg::ERR_NONE) begin
              if (imm_r) begin
                out_res_r  <= 1'b1;
                out_kind_r <= dpbst_pkg::KIND_PRE;
                out_pim_r  <= 1'b1;
              end else if (ready_q) begin
                out_res_r  <= 1'b1;
                out_kind_r <= rk_r;
                out_pim_r  <= pim_r;
                if (rk_r == dpbst_pkg::KIND_PRE) prech_r <= own_sa;
              end
            end
            state_r <= dpbst_pkg::SEQ_IDLE;
          end
        end
        default: state_r <= dpbst_pkg::SEQ_IDLE;
      endcase
    end
  end

`include "dram_pim_bank_state_tracker_assert.svh"

  `DPBST_ASSERT_NEXT(a_busy_after_take, in_ch.valid && in_ch.ready, state_r != dpbst_pkg::SEQ_IDLE, "request transfer did not start work")
  `DPBST_ASSERT_IMP(a_seq_onehot, 1'b1, $onehot(state_r), "sequencer state not one-hot")
  `DPBST_ASSERT_IMP(a_div_count, state_r == dpbst_pkg::SEQ_DIV, cnt_r <= 5'(dpbst_pkg::DIV_STEPS), "divider step count overrun")
  `DPBST_ASSERT_IMP(a_err_range, out_valid_r, out_err_r <= dpbst_pkg::ERR_STATE, "bad error code")

endmodule

FILE: dv/tb_bank_tracker_chk.sv
// Checker for the DRAM bank state tracker: watches request and result transfers,
// predicts each result from its own copy of the bank state and compares fields.
// Depends on dpbst_pkg, dpbst_in_if and dpbst_out_if.
`timescale 1ns / 100ps

module tb_bank_tracker_chk (
  input  logic clk,
  input  logic rst_n,
  dpbst_in_if  in_ch,
  dpbst_out_if out_ch,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int   fail_count,
  output int   pending
);
  import dpbst_pkg::*;

  typedef struct packed {
    logic        res;
    kind_t       kind;
    logic        pim;
    logic [31:0] hits;
    logic [1:0]  err;
  } verdict_t;

  verdict_t verdict_q[$];

  logic        m_dpsa;
  logic [16:0] m_rps;
  logic [1:0]  m_nstate, m_pstate;
  int          m_nrow, m_prow, m_presa;
  logic [31:0] m_hits;
  cyc_t        m_tsame[16], m_tdiff[16], m_tmsame[16], m_tmdiff[16];
  cyc_t        m_actdone;

  function automatic int subarray(int r);
    int d;
    d = (m_rps == 0) ? 1 : int'(m_rps);
    if (r == -1) return -1;
    if (r >= 0) return r / d;
    return -((-r) / d);
  endfunction

  function automatic cyc_t mx(cyc_t a, cyc_t b);
    return (a > b) ? a : b;
  endfunction

  task automatic query_bank(kind_t k, int r, logic p, cyc_t now, inout verdict_t v);
    int sa, d;
    logic [1:0] st;
    kind_t rq;
    logic ssub, srow;
    cyc_t lim;
    sa = subarray(r);
    if (p) begin
      st = m_pstate;
      if (m_nstate == BANK_OPEN && sa == subarray(m_nrow)) st = BANK_OPEN;
    end else begin
      st = m_nstate;
      if (m_pstate == BANK_OPEN && sa == subarray(m_prow)) st = BANK_OPEN;
    end
    if (st == BANK_CLOSED) begin
      case (k)
        KIND_RD, KIND_WR, KIND_D2G, KIND_COMP, KIND_MAC: rq = KIND_ACT;
        KIND_REF: begin
          if (m_pstate == BANK_CLOSED) rq = KIND_REF;
          else begin
            v.res = 1; v.kind = KIND_PRE; v.pim = 1;
            m_presa = subarray(p ? m_prow : m_nrow);
            return;
          end
        end
        KIND_H2G, KIND_READRES, KIND_MACINTR: rq = k;
        default: begin v.err = ERR_ILLEGAL; return; end
      endcase
    end else if (st == BANK_OPEN) begin
      case (k)
        KIND_RD, KIND_WR, KIND_D2G: rq = (r == m_nrow) ? k : KIND_PRE;
        KIND_REF: rq = KIND_PRE;
        KIND_COMP, KIND_MAC: rq = (r == (p ? m_prow : m_nrow)) ? k : KIND_PRE;
        KIND_READRES, KIND_H2G, KIND_MACINTR: rq = k;
        default: begin v.err = ERR_ILLEGAL; return; end
      endcase
    end else begin
      v.err = ERR_STATE;
      return;
    end
    if (p) begin
      d = sa - subarray(m_nrow);
      srow = (r == m_prow);
    end else begin
      d = sa - subarray(m_prow);
      srow = (sa == subarray(m_nrow));
    end
    ssub = (d >= -1 && d <= 1);
    if (rq == KIND_ACT && m_presa == sa) srow = 1;
    if (m_dpsa) begin
      if (ssub && srow) lim = mx(m_tsame[rq], m_tmsame[rq]);
      else if (!ssub && !srow) lim = mx(m_tdiff[rq], m_tmdiff[rq]);
      else if (p && !ssub && srow) lim = mx(mx(m_actdone, m_tdiff[rq]), m_tmsame[rq]);
      else if (!p && ssub && !srow) lim = mx(m_tdiff[rq], m_tmsame[rq]);
      else lim = mx(m_tsame[rq], m_tmdiff[rq]);
    end else lim = mx(m_tsame[rq], m_tmsame[rq]);
    if (now >= lim) begin
      v.res = 1; v.kind = rq; v.pim = p;
      if (rq == KIND_PRE) m_presa = subarray(p ? m_prow : m_nrow);
    end
  endtask

  function automatic logic [1:0] apply_cmd(kind_t k, int r, logic p);
    logic [1:0] st;
    int sa;
    st = p ? m_pstate : m_nstate;
    if (st == BANK_OPEN) begin
      case (k)
        KIND_RD, KIND_WR: begin
          if (m_hits != 32'hFFFF_FFFF) m_hits++;
          return ERR_NONE;
        end
        KIND_READRES, KIND_D2G, KIND_H2G, KIND_COMP, KIND_MAC, KIND_MACINTR:
          return ERR_NONE;
        KIND_PRE: begin
          if (p) begin m_pstate = BANK_CLOSED; m_prow = -1; end
          else begin m_nstate = BANK_CLOSED; m_nrow = -1; m_hits = 0; end
          return ERR_NONE;
        end
        default: return ERR_ILLEGAL;
      endcase
    end
    if (st == BANK_CLOSED) begin
      case (k)
        KIND_REF, KIND_H2G, KIND_READRES: return ERR_NONE;
        KIND_ACT: begin
          if (p) begin m_pstate = BANK_OPEN; m_prow = r; end
          else begin m_nstate = BANK_OPEN; m_nrow = r; end
          return ERR_NONE;
        end
        KIND_SREFIN: begin m_nstate = BANK_SREF; return ERR_NONE; end
        KIND_PRE: begin
          if (!m_dpsa) return ERR_ILLEGAL;
          sa = subarray(r);
          if (sa == subarray(m_nrow)) begin
            m_nstate = BANK_CLOSED; m_nrow = -1; m_hits = 0;
          end
          if (sa == subarray(m_prow)) begin m_pstate = BANK_CLOSED; m_prow = -1; end
          return ERR_NONE;
        end
        default: return ERR_ILLEGAL;
      endcase
    end
    return ERR_STATE;
  endfunction

  always @(posedge clk) begin
    verdict_t v, got;
    if (!rst_n) begin
      m_dpsa = 0; m_rps = RPS_RESET;
      m_nstate = BANK_CLOSED; m_pstate = BANK_CLOSED;
      m_nrow = -1; m_prow = -1; m_presa = -1; m_hits = 0; m_actdone = 0;
      for (int i = 0; i < 16; i++) begin
        m_tsame[i] = 0; m_tdiff[i] = 0; m_tmsame[i] = 0; m_tmdiff[i] = 0;
      end
      verdict_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr == CFG_ADDR_MODE) m_dpsa = cfg_pwdata[0];
        else if (cfg_paddr == CFG_ADDR_RPS) m_rps = cfg_pwdata[16:0];
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.ready_res, out_ch.ready_kind, out_ch.ready_for_pim,
                out_ch.row_hits, out_ch.error_code};
        if (verdict_q.size() == 0) begin
          fail_count++;
          $display("%0t: result transfer with nothing expected, got %p", $realtime, got);
        end else begin
          v = verdict_q.pop_front();
          if (got !== v) begin
            fail_count++;
            $display("%0t: mismatch expected %p actual %p", $realtime, v, got);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        v = '0;
        case (in_ch.req_type)
          REQ_QUERY: query_bank(in_ch.cmd_kind, int'(in_ch.row), in_ch.for_pim,
                                in_ch.now, v);
          REQ_APPLY: v.err = apply_cmd(in_ch.cmd_kind, int'(in_ch.row), in_ch.for_pim);
          REQ_T_SAME: m_tsame[in_ch.cmd_kind] = mx(m_tsame[in_ch.cmd_kind], in_ch.time_value);
          REQ_T_DIFF: m_tdiff[in_ch.cmd_kind] = mx(m_tdiff[in_ch.cmd_kind], in_ch.time_value);
          REQ_T_MAC_SAME:
            m_tmsame[in_ch.cmd_kind] = mx(m_tmsame[in_ch.cmd_kind], in_ch.time_value);
          REQ_T_MAC_DIFF:
            m_tmdiff[in_ch.cmd_kind] = mx(m_tmdiff[in_ch.cmd_kind], in_ch.time_value);
          REQ_ACT_DONE: m_actdone = mx(m_actdone, in_ch.time_value);
          REQ_CLR_MAC: m_tmsame[in_ch.cmd_kind] = 0;
          REQ_CLR_MACD: m_tmdiff[in_ch.cmd_kind] = 0;
          default: ;
        endcase
        v.hits = m_hits;
        verdict_q.push_back(v);
      end
    end
    pending = verdict_q.size();
  end
endmodule

FILE: dv/tb_top.sv
// Testbench top for the DRAM bank state tracker: clock, reset, APB setup,
// request and result handshakes with random idling; checker gives the verdict count.
// Depends on dpbst_pkg, the channel interfaces, the block and tb_bank_tracker_chk.
`timescale 1ns / 100ps

module tb_top;
  import dpbst_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk, rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int fail_count, pending, idle_cycles, n_items;
  bit calm;

  dpbst_in_if  in_ch();
  dpbst_out_if out_ch();

  dram_pim_bank_state_tracker dut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  tb_bank_tracker_chk chk (
    .clk, .rst_n, .in_ch(in_ch), .out_ch(out_ch), .cfg_psel, .cfg_penable,
    .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .fail_count, .pending
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || cfg_psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || ($urandom_range(99) >= 29);
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= addr; cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic send(logic [3:0] rq, kind_t k, row_t r, logic p, cyc_t nw, cyc_t tv);
    if (!calm) begin
      while ($urandom_range(99) < 29) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid <= 1; in_ch.req_type <= rq; in_ch.cmd_kind <= k;
    in_ch.row <= r; in_ch.for_pim <= p; in_ch.now <= nw; in_ch.time_value <= tv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    n_items++;
  endtask

  function automatic row_t pick_row(int nrows);
    case ($urandom_range(9))
      0: return ROW_NONE;
      1: return 17'sh0FFFF;
      2: return row_t'($urandom);
      default: return row_t'($urandom_range(nrows - 1));
    endcase
  endfunction

  function automatic cyc_t pick_time();
    case ($urandom_range(5))
      0: return 64'hFFFF_FFFF_FFFF_FFFF;
      1: return {$urandom, $urandom};
      default: return cyc_t'($urandom_range(2000));
    endcase
  endfunction

  task automatic random_phase(int count, int nrows);
    kind_t k;
    int sel;
    repeat (count) begin
      k = kind_t'($urandom_range(15));
      sel = $urandom_range(99);
      if (sel < 40) send(REQ_QUERY, k, pick_row(nrows), 1'($urandom_range(1)), pick_time(),
                         pick_time());
      else if (sel < 70) begin
        case ($urandom_range(5))
          0: k = KIND_ACT;
          1: k = KIND_PRE;
          2: k = KIND_RD;
          3: k = KIND_WR;
          default: ;
        endcase
        if (k == KIND_SREFIN && $urandom_range(9) != 0) k = KIND_ACT;
        send(REQ_APPLY, k, pick_row(nrows), 1'($urandom_range(1)), pick_time(),
             pick_time());
      end else send(4'($urandom_range(2, 15)), k, pick_row(nrows), 1'($urandom_range(1)),
                    pick_time(), pick_time());
    end
  endtask

  initial begin
    rst_n = 0; calm = 0; n_items = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    in_ch.valid = 0; in_ch.req_type = '0; in_ch.cmd_kind = '0; in_ch.row = '0;
    in_ch.for_pim = 0; in_ch.now = '0; in_ch.time_value = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: every kind queried; activate, read and precharge applied on normal and compute rows
    for (int k = 0; k < 16; k++) send(REQ_QUERY, kind_t'(k), 17'sd3, k[0], 64'd0, 64'd0);
    send(REQ_T_SAME, KIND_ACT, 17'sd0, 1'b0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send(REQ_QUERY, KIND_RD, 17'sd3, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0);
    send(REQ_CLR_MAC, KIND_ACT, ROW_NONE, 1'b1, 64'd0, 64'd0);
    send(REQ_APPLY, KIND_ACT, 17'sd3, 1'b1, 64'd0, 64'd0);
    send(REQ_QUERY, KIND_REF, 17'sd9000, 1'b0, 64'd0, 64'd0);
    send(REQ_APPLY, KIND_ACT, 17'sd65535, 1'b0, 64'd0, 64'd0);
    send(REQ_APPLY, KIND_RD, 17'sd65535, 1'b0, 64'd0, 64'd0);
    send(REQ_APPLY, KIND_PRE, 17'sd3, 1'b0, 64'd0, 64'd0);
    send(4'd15, KIND_PWRITE, ROW_NONE, 1'b1, 64'd0, 64'd0);
    drain();

    calm = 1;
    random_phase(60, 64);
    drain();
    calm = 0;
    for (int ph = 0; ph < 5; ph++) begin
      reg_write(CFG_ADDR_MODE, ph[0] ? 32'hFFFF_FFFE : 32'd1);
      case (ph)
        0: reg_write(CFG_ADDR_RPS, 32'd0);
        1: reg_write(CFG_ADDR_RPS, 32'd1);
        2: reg_write(CFG_ADDR_RPS, 32'h1_0000);
        3: reg_write(CFG_ADDR_RPS, 32'hFFFE_FFFF);
        default: reg_write(CFG_ADDR_RPS, 32'd8);
      endcase
      random_phase(115, (ph == 2) ? 65536 : 48);
      if (ph == 3) begin
        send(REQ_APPLY, KIND_SREFIN, ROW_NONE, 1'b0, 64'd0, 64'd0);
        send(REQ_QUERY, KIND_RD, 17'sd1, 1'b0, 64'd0, 64'd0);
      end
      drain();
      reg_write(CFG_ADDR_MODE, 32'd0);
    end
    drain();

    $display("covered %0d requests over both bank modes and six subarray sizes", n_items);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
